[hw/rtl/ookr_pkg.sv]
// Package for the OOK repeat packet receiver: sizes, register map, payload
// structs, inter-module control structs and state encodings.
// No dependencies; every other RTL file imports it.
`default_nettype none

package ookr_pkg;

  // Packet format and batch size
  localparam int unsigned Repeats   = 7;
  localparam int unsigned DataBits  = 8;
  localparam int unsigned ChanW     = 4;
  localparam int unsigned VoteW     = 16;
  localparam int unsigned MsW       = 8;
  localparam int unsigned SlotW     = 4;
  localparam int unsigned PlW       = 5;
  localparam int unsigned StoreAw   = $clog2(Repeats);
  localparam int unsigned CntW      = $clog2(Repeats + 1);
  localparam int unsigned LastSlot  = DataBits + 5;
  localparam int unsigned FirstData = 6;

  // Register map (APB, 32-bit registers at 4-byte steps)
  localparam int unsigned ApbDw    = 32;
  localparam int unsigned ApbAw    = 3;
  localparam int unsigned RegIdxW  = 1;
  localparam logic [RegIdxW-1:0] RegPulseLength  = 1'b0;
  localparam logic [RegIdxW-1:0] RegListenChannel = 1'b1;
  localparam logic [PlW-1:0]     PulseLengthRst   = PlW'(5);
  localparam logic [ChanW-1:0]   ListenChannelRst = ChanW'(3);

  // Channel payloads
  typedef struct packed {
    logic level;
    logic ms_tick;
  } in_item_t;

  typedef struct packed {
    logic                led;
    logic [DataBits-1:0] last_value;
    logic                receiving;
    logic                batch_done;
  } out_item_t;

  // Slicer to top: what the current sample does to the packet
  typedef struct packed {
    logic                receiving;
    logic                pkt_end;
    logic                match;
    logic [DataBits-1:0] data;
  } slice_evt_t;

  // Top to search unit: packet store write port
  typedef struct packed {
    logic               en;
    logic [StoreAw-1:0] addr;
    logic [DataBits-1:0] data;
  } store_wr_t;

  // Top to search unit: start of a duplicate search
  typedef struct packed {
    logic            start;
    logic [CntW-1:0] count;
  } search_req_t;

  // Search unit to top: search outcome
  typedef struct packed {
    logic                done;
    logic                found;
    logic [DataBits-1:0] value;
  } search_rsp_t;

  // Top-level control states
  typedef enum logic [2:0] {
    ST_RUN  = 3'b001,
    ST_KICK = 3'b010,
    ST_WAIT = 3'b100
  } top_state_e;

  // Search sequencer states
  typedef enum logic [4:0] {
    SR_IDLE   = 5'b00001,
    SR_REFRD  = 5'b00010,
    SR_REFCAP = 5'b00100,
    SR_CMP    = 5'b01000,
    SR_DONE   = 5'b10000
  } srch_state_e;

endpackage

`default_nettype wire

[hw/rtl/ookr_slicer.sv]
// Sync detection, slot timing and slot voting for the OOK receiver.
// Depends on ookr_pkg. Updates its state on each accepted sample.
`default_nettype none

module ookr_slicer
  import ookr_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic             clear_i,
  input  in_item_t         item_i,
  input  logic [PlW-1:0]   pulse_length_i,
  input  logic [ChanW-1:0] listen_channel_i,
  output slice_evt_t       evt_o
);

  localparam logic signed [VoteW-1:0] VoteMax = {1'b0, {(VoteW-1){1'b1}}};
  localparam logic signed [VoteW-1:0] VoteMin = {1'b1, {(VoteW-1){1'b0}}};

  logic                    prev_q, prev_d;
  logic                    inp_q, inp_d;
  logic [MsW-1:0]          ms_q, ms_d;
  logic [SlotW-1:0]        slot_q, slot_d;
  logic [SlotW-1:0]        dec_q, dec_d;
  logic signed [VoteW-1:0] vote_q, vote_d;
  logic [ChanW-1:0]        chan_q, chan_d;
  logic [DataBits-1:0]     data_q, data_d;

  logic [PlW-1:0]   slot_len;
  logic [MsW-1:0]   win_lo;
  logic [MsW-1:0]   win_hi;
  logic             bitval;
  logic             bad_sync;
  logic             match;
  logic             pkt_end;

  assign slot_len = (pulse_length_i == '0) ? PlW'(1) : pulse_length_i;
  assign win_lo   = (pulse_length_i == '0) ? '0 : MsW'(pulse_length_i - PlW'(1));
  assign win_hi   = MsW'({1'b0, pulse_length_i} + (PlW+1)'(1));

  // Next state for one sample: tick, then edge, then vote, then slot decision
  always_comb begin
    prev_d   = item_i.level;
    inp_d    = inp_q;
    ms_d     = ms_q;
    slot_d   = slot_q;
    dec_d    = dec_q;
    vote_d   = vote_q;
    chan_d   = chan_q;
    data_d   = data_q;
    bitval   = 1'b0;
    bad_sync = 1'b0;
    match    = 1'b0;
    pkt_end  = 1'b0;

    // millisecond tick
    if (item_i.ms_tick) begin
      if (inp_q) begin
        if ((ms_q + MsW'(1)) >= MsW'(slot_len)) begin
          ms_d   = '0;
          slot_d = slot_q + SlotW'(1);
        end else begin
          ms_d = ms_q + MsW'(1);
        end
      end else if (ms_q != {MsW{1'b1}}) begin
        ms_d = ms_q + MsW'(1);
      end
    end

    // sync search on level edges
    if (!inp_q && (item_i.level != prev_q)) begin
      if (item_i.level && (ms_d >= win_lo) && (ms_d <= win_hi)) begin
        inp_d  = 1'b1;
        slot_d = '0;
        dec_d  = '0;
        vote_d = '0;
        chan_d = '0;
      end
      ms_d = '0;
    end

    if (inp_d) begin
      // saturating vote
      if (item_i.level) begin
        if (vote_d != VoteMax) vote_d = vote_d + VoteW'(1);
      end else begin
        if (vote_d != VoteMin) vote_d = vote_d - VoteW'(1);
      end

      // slot finished
      if (dec_d != slot_d) begin
        bitval   = (vote_d > 0);
        vote_d   = '0;
        bad_sync = ((dec_d == SlotW'(0)) && !bitval) || ((dec_d == SlotW'(1)) && bitval);
        if (bad_sync) begin
          inp_d  = 1'b0;
          slot_d = '0;
          dec_d  = '0;
          ms_d   = '0;
        end else begin
          match = (chan_d == listen_channel_i);
          if ((dec_d >= SlotW'(2)) && (dec_d < SlotW'(FirstData))) begin
            chan_d = {chan_d[ChanW-2:0], bitval};
          end else if ((dec_d >= SlotW'(FirstData)) && match) begin
            data_d = {data_d[DataBits-2:0], bitval};
          end
          if (dec_d >= SlotW'(LastSlot)) begin
            pkt_end = 1'b1;
            inp_d   = 1'b0;
            slot_d  = '0;
            dec_d   = '0;
            ms_d    = '0;
          end else begin
            dec_d = slot_d;
          end
        end
      end
    end
  end

  assign evt_o.receiving = inp_d;
  assign evt_o.pkt_end   = pkt_end;
  assign evt_o.match     = match;
  assign evt_o.data      = data_d;

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= 1'b0;
      inp_q  <= 1'b0;
      ms_q   <= '0;
      slot_q <= '0;
      dec_q  <= '0;
      vote_q <= '0;
      chan_q <= '0;
    end else if (step_i) begin
      prev_q <= prev_d;
      inp_q  <= inp_d;
      ms_q   <= ms_d;
      slot_q <= slot_d;
      dec_q  <= dec_d;
      vote_q <= vote_d;
      chan_q <= chan_d;
    end
  end

  // data shifter: the store entry being filled, shifted only while the channel matches
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_q <= '0;
    end else if (step_i) begin
      data_q <= clear_i ? '0 : data_d;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/ookr_search.sv]
// Packet store and duplicate search unit: one 8-bit comparator walked over
// stored pairs by a small sequencer. Depends on ookr_pkg.
`default_nettype none

module ookr_search
  import ookr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  store_wr_t   wr_i,
  input  search_req_t req_i,
  output search_rsp_t rsp_o
);

  logic [DataBits-1:0] mem_q [Repeats];
  logic [DataBits-1:0] rdata_q;
  logic [StoreAw-1:0]  raddr;

  srch_state_e         state_q, state_d;
  logic [StoreAw-1:0]  i_q, i_d;
  logic [StoreAw-1:0]  l_q, l_d;
  logic [StoreAw-1:0]  last_q, last_d;
  logic [DataBits-1:0] ref_q, ref_d;
  logic                found_q, found_d;
  logic [DataBits-1:0] value_q, value_d;

  // Store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_i.en) mem_q[wr_i.addr] <= wr_i.data;
    rdata_q <= mem_q[raddr];
  end

  // Sequencer: highest reference index first, first hit wins
  always_comb begin
    state_d = state_q;
    i_d     = i_q;
    l_d     = l_q;
    last_d  = last_q;
    ref_d   = ref_q;
    found_d = found_q;
    value_d = value_q;
    raddr   = '0;
    unique case (state_q)
      SR_IDLE: begin
        if (req_i.start) begin
          found_d = 1'b0;
          last_d  = StoreAw'(req_i.count - CntW'(1));
          i_d     = StoreAw'(req_i.count - CntW'(1));
          state_d = (req_i.count < CntW'(2)) ? SR_DONE : SR_REFRD;
        end
      end
      SR_REFRD: begin
        raddr   = i_q;
        l_d     = '0;
        state_d = SR_REFCAP;
      end
      SR_REFCAP: begin
        raddr   = l_q;
        ref_d   = rdata_q;
        state_d = SR_CMP;
      end
      SR_CMP: begin
        raddr = (l_q == last_q) ? '0 : l_q + StoreAw'(1);
        if ((l_q != i_q) && (rdata_q == ref_q)) begin
          found_d = 1'b1;
          value_d = ref_q;
          state_d = SR_DONE;
        end else if (l_q == last_q) begin
          if (i_q == '0) begin
            state_d = SR_DONE;
          end else begin
            i_d     = i_q - StoreAw'(1);
            state_d = SR_REFRD;
          end
        end else begin
          l_d = l_q + StoreAw'(1);
        end
      end
      SR_DONE: begin
        state_d = SR_IDLE;
      end
      default: begin
        state_d = SR_IDLE;
      end
    endcase
  end

  assign rsp_o.done  = (state_q == SR_DONE);
  assign rsp_o.found = found_q;
  assign rsp_o.value = value_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SR_IDLE;
      found_q <= 1'b0;
    end else begin
      state_q <= state_d;
      found_q <= found_d;
    end
  end

  // sequencer datapath
  always_ff @(posedge clk_i) begin
    i_q     <= i_d;
    l_q     <= l_d;
    last_q  <= last_d;
    ref_q   <= ref_d;
    value_q <= value_d;
  end

endmodule

`default_nettype wire

[hw/rtl/ook_repeat_packet_receiver.sv]
// A sample that ends no batch has its result registered in the cycle after transfer.
// A sample that ends a batch runs the duplicate search; its length is set by the single
// store read port. Throughput: one sample per cycle outside batch ends while the result
// is not stalled; no input taken while searching.
// Reset: asynchronous active low; registers at 5 ms and channel 3, state cleared.
// The packet store needs no clearing: a search reads only entries of the current batch.
`default_nettype none

module ook_repeat_packet_receiver
  import ookr_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  // sample channel
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  in_item_t         in_item_i,
  // result channel
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output out_item_t        out_item_o,
  // configuration
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [ApbAw-1:0] paddr,
  input  logic [ApbDw-1:0] pwdata,
  output logic [ApbDw-1:0] prdata,
  output logic             pready
);

  logic [PlW-1:0]      pulse_length_q;
  logic [ChanW-1:0]    listen_channel_q;
  logic [RegIdxW-1:0]  reg_idx;
  logic                cfg_wr;

  top_state_e          state_q, state_d;
  logic [CntW-1:0]     good_q, good_d;
  logic [CntW-1:0]     bad_q, bad_d;
  logic [DataBits-1:0] chosen_q, chosen_d;
  logic                led_q, led_d;
  logic                out_valid_q, out_valid_d;
  out_item_t           out_item_q, out_item_d;

  logic                accept;
  logic                out_free;
  logic                batch_end;
  logic                data_clr;
  slice_evt_t          evt;
  store_wr_t           wr;
  search_req_t         req;
  search_rsp_t         rsp;

  // Configuration port
  assign pready  = 1'b1;
  assign reg_idx = paddr[ApbAw-1 -: RegIdxW];
  assign cfg_wr  = psel && penable && pwrite;

  always_comb begin
    unique case (reg_idx)
      RegPulseLength:   prdata = ApbDw'(pulse_length_q);
      RegListenChannel: prdata = ApbDw'(listen_channel_q);
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pulse_length_q   <= PulseLengthRst;
      listen_channel_q <= ListenChannelRst;
    end else if (cfg_wr) begin
      if (reg_idx == RegPulseLength)   pulse_length_q   <= pwdata[PlW-1:0];
      if (reg_idx == RegListenChannel) listen_channel_q <= pwdata[ChanW-1:0];
    end
  end

  // Input handshake: take a sample in the run state when the result register frees up
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((state_q == ST_RUN) && out_free);
  assign accept     = in_valid_i && !in_stall_o;

  // Packet end that fills the batch; the shifter restarts once its entry is stored or the batch ends
  assign batch_end = evt.pkt_end &&
                     (({1'b0, good_q} + {1'b0, bad_q} + (CntW+1)'(1)) >= (CntW+1)'(Repeats));
  assign data_clr  = accept && evt.pkt_end && (evt.match || batch_end);

  ookr_slicer u_slicer (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .step_i           (accept),
    .clear_i          (data_clr),
    .item_i           (in_item_i),
    .pulse_length_i   (pulse_length_q),
    .listen_channel_i (listen_channel_q),
    .evt_o            (evt)
  );

  // Store a matching packet at the current good count
  assign wr.en   = accept && evt.pkt_end && evt.match;
  assign wr.addr = StoreAw'(good_q);
  assign wr.data = evt.data;

  assign req.start = (state_q == ST_KICK);
  assign req.count = good_q;

  ookr_search u_search (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (wr),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  // Batch control and result register
  always_comb begin
    state_d     = state_q;
    good_d      = good_q;
    bad_d       = bad_q;
    chosen_d    = chosen_q;
    led_d       = led_q;
    out_item_d  = out_item_q;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      ST_RUN: begin
        if (accept) begin
          if (evt.pkt_end) begin
            if (evt.match) good_d = good_q + CntW'(1);
            else           bad_d  = bad_q + CntW'(1);
          end
          if (batch_end) begin
            state_d = ST_KICK;
          end else begin
            out_valid_d           = 1'b1;
            out_item_d.led        = led_q;
            out_item_d.last_value = chosen_q;
            out_item_d.receiving  = evt.receiving;
            out_item_d.batch_done = 1'b0;
          end
        end
      end
      ST_KICK: begin
        state_d = ST_WAIT;
      end
      ST_WAIT: begin
        if (rsp.done) begin
          chosen_d              = rsp.found ? rsp.value : chosen_q;
          led_d                 = chosen_d[0];
          good_d                = '0;
          bad_d                 = '0;
          out_valid_d           = 1'b1;
          out_item_d.led        = chosen_d[0];
          out_item_d.last_value = chosen_d;
          out_item_d.receiving  = 1'b0;
          out_item_d.batch_done = 1'b1;
          state_d               = ST_RUN;
        end
      end
      default: begin
        state_d = ST_RUN;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_RUN;
      good_q      <= '0;
      bad_q       <= '0;
      chosen_q    <= '0;
      led_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      good_q      <= good_d;
      bad_q       <= bad_d;
      chosen_q    <= chosen_d;
      led_q       <= led_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    out_item_q <= out_item_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

`default_nettype wire

[hw/rtl/ookr_checker.sv]
// Port-level checks for the OOK repeat packet receiver, bound to the top level.
// Depends on ookr_pkg.
`default_nettype none

module ookr_checker
  import ookr_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_stall_o,
  input  logic             out_valid_o,
  input  logic             out_stall_i,
  input  out_item_t        out_item_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("result changed while stalled");

  // no sample taken while a result is blocked
  a_no_take_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> in_stall_o)
    else $error("sample taken while result register blocked");

  // led mirrors the low bit of the chosen value
  a_led_bit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.led == out_item_o.last_value[0]))
    else $error("led differs from low bit of last value");

  // a batch end result never shows the receiver still receiving
  a_batch_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.batch_done |-> !out_item_o.receiving)
    else $error("batch end while still receiving");

endmodule

bind ook_repeat_packet_receiver ookr_checker u_ookr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);

`default_nettype wire
